[rtl/akq_pkg.sv]
`timescale 1ns / 1ps
// Package: shared types, constants and controller command/status structs for the key quicksort.
package akq_pkg;

    localparam int MaxItemsDefault = 64;
    localparam int KeyW = 32;
    localparam int TagW = 16;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    typedef struct packed {
        logic [15:0] item_tag;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic final_item;
    } t_in_item;

    typedef struct packed {
        logic [15:0] sorted_tag;
        logic signed [31:0] sorted_key;
        logic end_of_run;
    } t_out_item;

    // datapath operations requested by the controller
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_INIT   = 4'd2;
    localparam logic [3:0] OP_POP    = 4'd3;
    localparam logic [3:0] OP_RDPIV  = 4'd4;
    localparam logic [3:0] OP_RDJ    = 4'd5;
    localparam logic [3:0] OP_CMP    = 4'd6;
    localparam logic [3:0] OP_RDM    = 4'd7;
    localparam logic [3:0] OP_WRJ    = 4'd8;
    localparam logic [3:0] OP_FINRD  = 4'd9;
    localparam logic [3:0] OP_FINWR  = 4'd10;
    localparam logic [3:0] OP_PUSH   = 4'd11;
    localparam logic [3:0] OP_ORD    = 4'd12;
    localparam logic [3:0] OP_OEMIT  = 4'd13;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic stack_empty;
        logic range_ok;
        logic scan_done;
        logic cmp_le;
        logic out_last;
        logic set_empty;
    } t_status;

endpackage

[rtl/akq_datapath.sv]
`timescale 1ns / 1ps
// Datapath: item memories, range stack, partition registers and output register.
module akq_datapath
    import akq_pkg::*;
#(
    parameter int MAX_ITEMS = MaxItemsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    input  logic [1:0] i_axis,
    output t_status   o_status,
    output logic      o_strobe,
    output t_out_item o_result
);
    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = IW + 1;

    logic [KeyW-1:0] r_key_mem [MAX_ITEMS];
    logic [TagW-1:0] r_tag_mem [MAX_ITEMS];
    logic [2*IW-1:0] r_stk_mem [MAX_ITEMS];

    logic [CW-1:0] r_count, r_sp;
    logic [IW-1:0] r_lo, r_hi, r_j, r_pos;
    logic [CW-1:0] r_mark; // mark+1, never negative
    logic [KeyW-1:0] r_piv, r_ka, r_kb;
    logic [TagW-1:0] r_tpiv, r_ta, r_tb;
    logic [1:0] r_pend; // pending pushes
    logic [2*IW-1:0] r_top;
    logic r_strobe;
    t_out_item r_res;

    logic [KeyW-1:0] w_key;
    logic [CW-1:0] w_c;
    logic w_le;

    always_comb begin
        case (i_axis)
            AXIS_X:  w_key = i_item.coord_x;
            AXIS_Y:  w_key = i_item.coord_y;
            default: w_key = i_item.coord_z;
        endcase
    end

    assign w_le = $signed(r_ka) <= $signed(r_piv);
    assign w_c  = r_mark;

    // Memory port: registered reads; a swap writes the mark slot and, if distinct, the other slot
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                if (r_count < CW'(MAX_ITEMS)) begin
                    r_key_mem[r_count[IW-1:0]] <= w_key;
                    r_tag_mem[r_count[IW-1:0]] <= i_item.item_tag;
                end
            end
            OP_RDPIV: begin
                r_piv  <= r_key_mem[r_hi];
                r_tpiv <= r_tag_mem[r_hi];
            end
            OP_RDJ: begin
                r_ka <= r_key_mem[r_j];
                r_ta <= r_tag_mem[r_j];
            end
            OP_RDM, OP_FINRD: begin
                r_kb <= r_key_mem[r_mark[IW-1:0]];
                r_tb <= r_tag_mem[r_mark[IW-1:0]];
            end
            OP_WRJ: begin
                r_key_mem[r_mark[IW-1:0]] <= r_ka;
                r_tag_mem[r_mark[IW-1:0]] <= r_ta;
                if (r_j != r_mark[IW-1:0]) begin
                    r_key_mem[r_j] <= r_kb;
                    r_tag_mem[r_j] <= r_tb;
                end
            end
            OP_FINWR: begin
                r_key_mem[r_mark[IW-1:0]] <= r_piv;
                r_tag_mem[r_mark[IW-1:0]] <= r_tpiv;
                if (r_hi != r_mark[IW-1:0]) begin
                    r_key_mem[r_hi] <= r_kb;
                    r_tag_mem[r_hi] <= r_tb;
                end
            end
            OP_ORD: begin
                r_ka <= r_key_mem[r_pos];
                r_ta <= r_tag_mem[r_pos];
            end
            default: ;
        endcase
    end

    // Stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_INIT) begin
            r_stk_mem[0] <= {IW'(0), IW'(r_count - 1'b1)};
        end else if (i_cmd.op == OP_PUSH) begin
            if (r_pend[1]) begin
                r_stk_mem[r_sp[IW-1:0]] <= {IW'(w_c + 1'b1), r_hi};
            end else begin
                r_stk_mem[r_sp[IW-1:0]] <= {r_lo, IW'(w_c - 1'b1)};
            end
        end
        if (r_sp != '0) r_top <= r_stk_mem[IW'(r_sp - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sp     <= '0;
            r_strobe <= 1'b0;
            r_pend   <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (i_cmd.op)
                OP_LOAD: if (r_count < CW'(MAX_ITEMS)) r_count <= r_count + 1'b1;
                OP_INIT: begin
                    r_sp  <= (r_count > CW'(1)) ? CW'(1) : '0;
                    r_pos <= '0;
                end
                OP_POP: begin
                    r_sp   <= r_sp - 1'b1;
                    r_lo   <= r_top[2*IW-1:IW];
                    r_hi   <= r_top[IW-1:0];
                    r_j    <= r_top[2*IW-1:IW];
                    r_mark <= CW'(r_top[2*IW-1:IW]);
                end
                OP_CMP: if (!w_le) r_j <= r_j + 1'b1;
                OP_WRJ: begin
                    r_mark <= r_mark + 1'b1;
                    r_j    <= r_j + 1'b1;
                end
                OP_FINWR: begin
                    r_pend[1] <= (w_c + 1'b1) < CW'(r_hi);
                    r_pend[0] <= CW'(r_lo) + 1'b1 < w_c;
                end
                OP_PUSH: begin
                    if (r_pend[1]) begin
                        r_pend[1] <= 1'b0;
                        r_sp <= r_sp + 1'b1;
                    end else if (r_pend[0]) begin
                        r_pend[0] <= 1'b0;
                        r_sp <= r_sp + 1'b1;
                    end
                end
                OP_OEMIT: begin
                    r_strobe <= 1'b1;
                    r_res.sorted_tag <= r_ta;
                    r_res.sorted_key <= r_ka;
                    r_res.end_of_run <= (CW'(r_pos) + 1'b1 == r_count);
                    if (CW'(r_pos) + 1'b1 == r_count) r_count <= '0;
                    r_pos <= r_pos + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_status.stack_empty = (r_sp == '0);
    assign o_status.range_ok    = (r_lo < r_hi) && (CW'(r_hi) < r_count);
    assign o_status.scan_done   = (r_j == r_hi);
    assign o_status.cmp_le      = w_le;
    assign o_status.out_last    = (CW'(r_pos) + 1'b1 == r_count);
    assign o_status.set_empty   = (r_count == '0) || (r_pend == '0);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS)) else $error("item count overflow");
    a_stack_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CW'(MAX_ITEMS)) else $error("stack overflow");
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.end_of_run) |-> (r_count == '0))
        else $error("count not cleared after last result");
endmodule

[rtl/akq_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences load, partition passes, stack pushes and output.
module akq_ctrl
    import akq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_final,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);
    localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_WAITTOP = 4'd2, S_CHK = 4'd3,
        S_POP = 4'd4, S_RANGE = 4'd5, S_PIV = 4'd6, S_RDJ = 4'd7, S_CMP = 4'd8,
        S_RDM = 4'd9, S_WRJ = 4'd10, S_FRD = 4'd11, S_FWR = 4'd12, S_PUSH = 4'd13,
        S_ORD = 4'd14, S_OEM = 4'd15;

    logic [3:0] r_state, n_state;
    logic [3:0] w_op;

    always_comb begin
        n_state = r_state;
        w_op = OP_NONE;
        case (r_state)
            S_IDLE: if (i_start) begin
                w_op = OP_LOAD;
                if (i_final) n_state = S_INIT;
            end
            S_INIT: begin w_op = OP_INIT; n_state = S_WAITTOP; end
            S_WAITTOP: n_state = S_CHK;
            S_CHK: n_state = i_status.stack_empty ? S_ORD : S_POP;
            S_POP: begin w_op = OP_POP; n_state = S_RANGE; end
            S_RANGE: n_state = i_status.range_ok ? S_PIV : S_WAITTOP;
            S_PIV: begin w_op = OP_RDPIV; n_state = S_RDJ; end
            S_RDJ: begin
                if (i_status.scan_done) begin
                    n_state = S_FRD;
                end else begin
                    w_op = OP_RDJ;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_op = OP_CMP;
                n_state = i_status.cmp_le ? S_RDM : S_RDJ;
            end
            S_RDM: begin w_op = OP_RDM; n_state = S_WRJ; end
            S_WRJ: begin w_op = OP_WRJ; n_state = S_RDJ; end
            S_FRD: begin w_op = OP_FINRD; n_state = S_FWR; end
            S_FWR: begin w_op = OP_FINWR; n_state = S_PUSH; end
            S_PUSH: begin
                w_op = OP_PUSH;
                if (i_status.set_empty) n_state = S_WAITTOP;
            end
            S_ORD: begin w_op = OP_ORD; n_state = S_OEM; end
            S_OEM: begin
                w_op = OP_OEMIT;
                n_state = i_status.out_last ? S_IDLE : S_ORD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_cmd.op = w_op;
    assign o_busy = (r_state != S_IDLE);

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == OP_LOAD) |-> (r_state == S_IDLE)) else $error("load outside idle");
    a_final_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_final) |=> (r_state == S_INIT))
        else $error("sort not started");
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OEM && i_status.out_last) |=> !o_busy)
        else $error("no return to idle");
endmodule

[rtl/axis_key_quicksort_top.sv]
`timescale 1ns / 1ps
// Top level: key quicksort with command-style load and strobed results.
//   channel | signals                              | direction
//   item    | start, busy, i_item                  | in
//   result  | o_valid, o_result                    | out
//   axis    | i_cfg_valid, o_cfg_ready, i_cfg_data | in
// Each load writes one item. The last item starts an in-memory Lomuto sort: each compare
// reads one element and tests it against the pivot, and an element that moves is swapped
// with the mark slot. Each result is read and then emitted. Busy drops in the cycle that
// carries the last result. Results cannot be stalled. Reset is synchronous, active low.
module axis_key_quicksort_top
    import akq_pkg::*;
#(
    parameter int MAX_ITEMS = MaxItemsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;
    logic [1:0] r_axis;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_axis <= AXIS_X;
        else if (i_cfg_valid) r_axis <= i_cfg_data;
    end

    akq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_final(i_item.final_item),
        .i_status(w_status), .o_cmd(w_cmd), .o_busy(busy)
    );

    akq_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_item(i_item), .i_axis(r_axis),
        .o_status(w_status), .o_strobe(o_valid), .o_result(o_result)
    );
endmodule
